// ===== hdl/tsch_pkg.sv =====
`timescale 1ns / 1ps

package tsch_pkg;

    typedef enum logic [1:0] {
        F_TICK     = 2'd0,
        F_POST     = 2'd1,
        F_CREATE   = 2'd2,
        F_DISPATCH = 2'd3
    } t_func;

    localparam logic [7:0] CFG_RUN_ENABLE  = 8'd0;
    localparam logic [7:0] CFG_TIMER_EVENTS = 8'd1;

    localparam logic [15:0] TIMER_EVENTS_RST = 16'h0001;

    // request token as it travels down the chain
    typedef struct packed {
        t_func       func;
        logic [7:0]  id;
        logic [15:0] ev;
        logic [31:0] per;
        logic        rej;
        logic        found;
        logic        disp;
        logic [3:0]  dtask;
        logic [15:0] devents;
    } t_tok;

    typedef struct packed {
        logic        status;
        logic        disp;
        logic [3:0]  dtask;
        logic [15:0] devents;
    } t_res;

endpackage

// ===== hdl/tsch_cell.sv =====
`timescale 1ns / 1ps

module tsch_cell #(
    parameter int ID = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_run,
    input  logic [15:0]          i_tev,
    input  logic                 i_vld,
    input  tsch_pkg::t_tok       i_tok,
    output logic                 o_vld,
    output tsch_pkg::t_tok       o_tok
);
    import tsch_pkg::*;

    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_per, n_per;
    logic [15:0] r_ev, n_ev;
    logic        r_rdy, n_rdy;
    logic        r_exists, n_exists;
    logic        r_vld;
    t_tok        r_tok, n_tok;
    logic [31:0] cnt_inc;
    logic        hit;

    assign cnt_inc = r_cnt + 32'd1;
    assign hit     = (i_tok.id == 8'(ID)) && !i_tok.rej;

    always_comb begin
        n_cnt    = r_cnt;
        n_per    = r_per;
        n_ev     = r_ev;
        n_rdy    = r_rdy;
        n_exists = r_exists;
        n_tok    = i_tok;
        if (i_vld) begin
            unique case (i_tok.func)
                F_TICK: begin
                    if (i_run) begin
                        if (r_per != 32'd0 && cnt_inc >= r_per) begin
                            n_cnt = 32'd0;
                            n_ev  = r_ev | i_tev;
                            n_rdy = 1'b1;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                end
                F_POST: begin
                    if (hit) begin
                        n_ev  = r_ev | i_tok.ev;
                        n_rdy = 1'b1;
                    end
                end
                F_CREATE: begin
                    if (hit) begin
                        n_exists = 1'b1;
                        n_ev     = 16'd0;
                        n_cnt    = 32'd0;
                        n_per    = i_tok.per;
                    end
                end
                F_DISPATCH: begin
                    // first ready cell in chain order, from cell 0 up, wins
                    if (!i_tok.found && r_rdy) begin
                        n_tok.found = 1'b1;
                        n_rdy       = 1'b0;
                        if (r_exists) begin
                            n_tok.disp    = 1'b1;
                            n_tok.dtask   = 4'(ID);
                            n_tok.devents = r_ev;
                            n_ev          = 16'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_per    <= '0;
            r_ev     <= '0;
            r_rdy    <= 1'b0;
            r_exists <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_per    <= n_per;
            r_ev     <= n_ev;
            r_rdy    <= n_rdy;
            r_exists <= n_exists;
            r_vld    <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

// ===== hdl/event_timer_task_scheduler.sv =====
`timescale 1ns / 1ps

// Cooperative event-driven task scheduler with TASKS task slots.
// Request channel (i_valid/o_ready) carries one command: tick, post events,
// create task or dispatch. Every request yields exactly one response on the
// response channel (o_valid/i_ready): status, dispatched flag, task id and
// the events handed over.
// Config channel (i_cfg_valid/o_cfg_ready, always ready) writes run_enable
// (index 0) and timer_event_bits (index 1); write only while idle.
// Each task slot lives in one cell of a chain. A request enters cell 0 on
// acceptance and moves one cell per cycle, each cell acting on it as it
// passes; the dispatch search is the "found" flag riding along.
// The response is registered once the request leaves the last cell. A new
// request is taken only after the previous one has left the chain.
// A completed response waits in the output register; the next request is
// still taken, and its result parks in a one-entry holding register if the
// receiver keeps stalling. Requests are blocked while the chain is busy or that is full.
// Reset clears all task slots, run_enable to 0, timer_event_bits to 1.
module event_timer_task_scheduler #(
    parameter int TASKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_task_id,
    input  logic [15:0] i_event_bits,
    input  logic [31:0] i_period,
    input  logic        i_handler_present,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic        o_dispatched,
    output logic [3:0]  o_dispatch_task,
    output logic [15:0] o_dispatch_events
);
    import tsch_pkg::*;

    logic        r_run;
    logic [15:0] r_tev;
    logic        r_busy;
    logic        r_out_v, r_pend_v;
    t_res        r_out, r_pend;
    t_res        exit_res;
    t_tok        in_tok;
    logic        accept, take, bad_id;
    logic        vld [TASKS+1];
    t_tok        tok [TASKS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_tev <= TIMER_EVENTS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RUN_ENABLE:   r_run <= i_cfg_data[0];
                CFG_TIMER_EVENTS: r_tev <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_ready = !r_busy && !r_pend_v;
    assign accept  = i_valid && o_ready;
    assign bad_id  = i_task_id >= 8'(TASKS);

    always_comb begin
        in_tok         = '0;
        in_tok.func    = t_func'(i_func);
        in_tok.id      = i_task_id;
        in_tok.ev      = i_event_bits;
        in_tok.per     = i_period;
        in_tok.rej     = ((t_func'(i_func) == F_POST) && bad_id)
                      || ((t_func'(i_func) == F_CREATE) && (bad_id || !i_handler_present));
    end

    assign vld[0] = accept;
    assign tok[0] = in_tok;

    for (genvar g = 0; g < TASKS; g++) begin : g_chain
        tsch_cell #(
            .ID (g)
        ) u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_run   (r_run),
            .i_tev   (r_tev),
            .i_vld   (vld[g]),
            .i_tok   (tok[g]),
            .o_vld   (vld[g+1]),
            .o_tok   (tok[g+1])
        );
    end

    assign exit_res.status  = tok[TASKS].rej;
    assign exit_res.disp    = tok[TASKS].disp;
    assign exit_res.dtask   = tok[TASKS].dtask;
    assign exit_res.devents = tok[TASKS].devents;

    assign take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (vld[TASKS]) begin
                r_busy <= 1'b0;
            end

            if (r_pend_v) begin
                if (!r_out_v || take) begin
                    r_out_v  <= 1'b1;
                    r_pend_v <= 1'b0;
                end
            end else if (vld[TASKS]) begin
                if (!r_out_v || take) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_pend_v <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_v) begin
            if (!r_out_v || take) begin
                r_out <= r_pend;
            end
        end else if (vld[TASKS]) begin
            if (!r_out_v || take) begin
                r_out <= exit_res;
            end else begin
                r_pend <= exit_res;
            end
        end
    end

    assign o_valid           = r_out_v;
    assign o_status          = r_out.status;
    assign o_dispatched      = r_out.disp;
    assign o_dispatch_task   = r_out.dtask;
    assign o_dispatch_events = r_out.devents;

endmodule

// ===== tb/event_timer_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module event_timer_task_scheduler_tb;
    import tsch_pkg::*;

    localparam int TASKS = 16;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_PRINTED = 100;
    localparam logic [7:0] CFG_UNMAPPED = 8'hFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [7:0]  i_task_id = '0;
    logic [15:0] i_event_bits = '0;
    logic [31:0] i_period = '0;
    logic        i_handler_present = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_status;
    logic        o_dispatched;
    logic [3:0]  o_dispatch_task;
    logic [15:0] o_dispatch_events;

    event_timer_task_scheduler #(.TASKS(TASKS)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_task_id         (i_task_id),
        .i_event_bits      (i_event_bits),
        .i_period          (i_period),
        .i_handler_present (i_handler_present),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_dispatched      (o_dispatched),
        .o_dispatch_task   (o_dispatch_task),
        .o_dispatch_events (o_dispatch_events)
    );

    // scheduler state as the block should hold it
    logic [31:0]      tick_cnt   [TASKS];
    logic [31:0]      period_of  [TASKS];
    logic [15:0]      events_of  [TASKS];
    logic [TASKS-1:0] ready_mask;
    logic [TASKS-1:0] exists_mask;
    logic             run_en;
    logic [15:0]      timer_bits;

    t_res pending_resp[$];
    int   err_count = 0;
    int   idle_cycles = 0;

    // request side burst/gap shaping
    int burst_left = 0;
    int tx_gap_max = 0;

    // response side stall pattern
    int rx_stall_max = 0;
    int rx_left = 0;
    bit rx_on = 1'b1;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    function automatic void clear_schedule();
        for (int t = 0; t < TASKS; t++) begin
            tick_cnt[t]  = '0;
            period_of[t] = '0;
            events_of[t] = '0;
        end
        ready_mask  = '0;
        exists_mask = '0;
        run_en      = 1'b0;
        timer_bits  = TIMER_EVENTS_RST;
    endfunction

    function automatic t_res schedule_step(input t_func f, input logic [7:0] id,
                                           input logic [15:0] ev, input logic [31:0] per,
                                           input logic hp);
        t_res r;
        bit   picked;
        r      = '0;
        picked = 1'b0;
        case (f)
            F_TICK: begin
                if (run_en) begin
                    for (int t = 0; t < TASKS; t++)
                        tick_cnt[t] = tick_cnt[t] + 32'd1;
                    for (int t = 0; t < TASKS; t++) begin
                        if (period_of[t] != 0 && tick_cnt[t] >= period_of[t]) begin
                            tick_cnt[t]   = '0;
                            events_of[t]  = events_of[t] | timer_bits;
                            ready_mask[t] = 1'b1;
                        end
                    end
                end
            end
            F_POST: begin
                if (id < TASKS) begin
                    events_of[id]  = events_of[id] | ev;
                    ready_mask[id] = 1'b1;
                end else begin
                    r.status = 1'b1;
                end
            end
            F_CREATE: begin
                if (id < TASKS && hp) begin
                    exists_mask[id] = 1'b1;
                    events_of[id]   = '0;
                    tick_cnt[id]    = '0;
                    period_of[id]   = per;
                end else begin
                    r.status = 1'b1;
                end
            end
            default: begin
                // lowest ready slot wins; a slot never created just loses its ready bit
                for (int t = 0; t < TASKS; t++) begin
                    if (!picked && ready_mask[t]) begin
                        picked        = 1'b1;
                        ready_mask[t] = 1'b0;
                        if (exists_mask[t]) begin
                            r.disp       = 1'b1;
                            r.dtask      = t[3:0];
                            r.devents    = events_of[t];
                            events_of[t] = '0;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input t_func f, input logic [7:0] id, input logic [15:0] ev,
                                input logic [31:0] per, input logic hp);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (tx_gap_max > 0)
                gap = $urandom_range(0, tx_gap_max);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_func            <= f;
        i_task_id         <= id;
        i_event_bits      <= ev;
        i_period          <= per;
        i_handler_present <= hp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_resp.push_back(schedule_step(f, id, ev, per, hp));
    endtask

    task automatic drain_responses();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_resp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_RUN_ENABLE)
            run_en = data[0];
        else if (idx == CFG_TIMER_EVENTS)
            timer_bits = data[15:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_on   = !rx_on;
            rx_left = rx_on ? $urandom_range(1, 24) : $urandom_range(1, rx_stall_max + 1);
        end
        rx_left--;
        i_ready <= rx_on || rx_stall_max == 0;
    end

    always @(posedge i_clk) begin : check_resp
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_resp.size() == 0) begin
                report_mismatch("response with none outstanding", 1, 0);
            end else begin
                want = pending_resp.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_dispatched !== want.disp)
                    report_mismatch("dispatched", o_dispatched, want.disp);
                if (o_dispatch_task !== want.dtask)
                    report_mismatch("dispatch_task", o_dispatch_task, want.dtask);
                if (o_dispatch_events !== want.devents)
                    report_mismatch("dispatch_events", o_dispatch_events, want.devents);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_reset_state();
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        // stopped after reset: tick must leave everything alone
        send_request(F_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(F_DISPATCH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        drain_responses();
    endtask

    task automatic test_task_lifecycle();
        rx_stall_max = 6;
        send_request(F_POST, 8'd3, 16'hFFFF, 32'd0, 1'b0);
        // slot 3 never created: ready dropped, events stay
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_CREATE, 8'd3, 16'h0000, 32'd2, 1'b0);
        send_request(F_CREATE, 8'd16, 16'h0000, 32'd2, 1'b1);
        send_request(F_POST, 8'hFF, 16'hFFFF, 32'd0, 1'b1);
        send_request(F_CREATE, 8'd3, 16'h0000, 32'd2, 1'b1);
        send_request(F_POST, 8'd3, 16'h8001, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_CREATE, 8'd15, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        send_request(F_POST, 8'd15, 16'h0000, 32'd0, 1'b0);
        send_request(F_POST, 8'd0, 16'h1234, 32'd0, 1'b0);
        // create keeps the ready bit but wipes the events
        send_request(F_CREATE, 8'd0, 16'h0000, 32'd1, 1'b1);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        drain_responses();
    endtask

    task automatic test_timer_expiry();
        write_reg(CFG_RUN_ENABLE, 32'd1);
        write_reg(CFG_TIMER_EVENTS, 32'h0000_FFFF);
        send_request(F_TICK, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_TICK, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        drain_responses();
        write_reg(CFG_TIMER_EVENTS, 32'hFFFF_0000);
        send_request(F_TICK, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        drain_responses();
    endtask

    task automatic test_config_regs();
        // unmapped index must not disturb either register
        write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
        write_reg(CFG_RUN_ENABLE, 32'hFFFF_FFFE);
        send_request(F_TICK, 8'd0, 16'h0000, 32'd0, 1'b0);
        send_request(F_DISPATCH, 8'd0, 16'h0000, 32'd0, 1'b0);
        drain_responses();
    endtask

    task automatic test_random_traffic();
        logic        run_sel  [5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        logic [31:0] bits_sel [5];
        int          count_sel[5] = '{380, 380, 100, 380, 380};
        int          gap_sel  [5] = '{0, 40, 8, 3, 20};
        int          stall_sel[5] = '{0, 30, 40, 2, 12};
        t_func       f;
        logic [7:0]  id;
        logic [15:0] ev;
        logic [31:0] per;
        logic        hp;
        int          pick;
        bits_sel = '{32'h0000_0001, $urandom, 32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 5; ph++) begin
            drain_responses();
            write_reg(CFG_RUN_ENABLE, {16'($urandom_range(0, 65535)), 15'd0, run_sel[ph]});
            write_reg(CFG_TIMER_EVENTS, bits_sel[ph]);
            tx_gap_max   = gap_sel[ph];
            rx_stall_max = stall_sel[ph];
            for (int n = 0; n < count_sel[ph]; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    f = F_TICK;
                else if (pick < 52)
                    f = F_POST;
                else if (pick < 65)
                    f = F_CREATE;
                else
                    f = F_DISPATCH;
                if ($urandom_range(0, 19) == 0)
                    id = 8'($urandom_range(TASKS, 255));
                else
                    id = 8'($urandom_range(0, TASKS - 1));
                if ($urandom_range(0, 3) == 0)
                    ev = 16'd1 << $urandom_range(0, 15);
                else
                    ev = 16'($urandom);
                case ($urandom_range(0, 9))
                    0: per = 32'd0;
                    1: per = 32'hFFFF_FFFF;
                    2: per = $urandom;
                    default: per = $urandom_range(1, 6);
                endcase
                hp = $urandom_range(0, 9) != 0;
                send_request(f, id, ev, per, hp);
            end
        end
        drain_responses();
    endtask

    initial begin
        clear_schedule();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_task_lifecycle();
        test_timer_expiry();
        test_config_regs();
        test_random_traffic();
        rx_stall_max = 0;
        repeat (2 * TASKS + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tsch_pkg.sv
hdl/tsch_cell.sv
hdl/event_timer_task_scheduler.sv
tb/event_timer_task_scheduler_tb.sv
